// ===== hw/rtl/xsph_velocity_smoothing_macros.svh =====
// Assertion macros shared by the XSPH velocity smoothing RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef XSPH_VELOCITY_SMOOTHING_MACROS_SVH
`define XSPH_VELOCITY_SMOOTHING_MACROS_SVH

// Checked on every clock edge outside reset.
`define XSPH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define XSPH_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/xsph_pkg.sv =====
// Types and constants of the XSPH velocity smoothing block.
// No dependencies; used by the controller, the datapath and the top level.
package xsph_pkg;

   localparam int NW = 45;

   localparam logic [63:0] SUM_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] DIST_CLAMP = 64'd33554432;
   localparam logic [63:0] QUOT_CLAMP = 64'h0000_0100_0000_0000;
   localparam logic [47:0] WEIGHT_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [5:0]  SHIFT_RESET = 6'd32;

   typedef enum logic [1:0] {
      CSR_GAIN   = 2'd0,
      CSR_RADIUS = 2'd1,
      CSR_SHIFT  = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_DIST, OP_SQ, OP_WGT, OP_CUBE, OP_PLO, OP_PHI,
      OP_ACC, OP_DIV_INIT, OP_DIV_STEP, OP_CORR, OP_PASS, OP_EMIT
   } dp_op_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DIST, S_SQ, S_WGT, S_CUBE, S_PLO, S_PHI, S_ACC, S_END,
      S_DIV_INIT, S_DIV, S_CORR, S_PASS, S_EMIT
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] axis;
      logic       req_ready;
   } dp_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_action;
      logic req_is_self;
      logic item_last;
      logic in_range;
      logic pass_through;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/xsph_req_if.sv =====
// Input channel of the XSPH velocity smoothing block: valid, ready and one item.
// No dependencies.
interface xsph_req_if #(parameter int VALUE_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic signed [VALUE_BITS-1:0] pos_x;
   logic signed [VALUE_BITS-1:0] pos_y;
   logic signed [VALUE_BITS-1:0] pos_z;
   logic signed [VALUE_BITS-1:0] vel_x;
   logic signed [VALUE_BITS-1:0] vel_y;
   logic signed [VALUE_BITS-1:0] vel_z;
   logic                         is_self;
   logic                         last;

   modport source (output valid, action, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   is_self, last, input ready);
   modport sink (input valid, action, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 is_self, last, output ready);
endinterface

// ===== hw/rtl/xsph_rsp_if.sv =====
// Result channel of the XSPH velocity smoothing block: valid, ready and one velocity.
// No dependencies.
interface xsph_rsp_if #(parameter int VALUE_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] new_vel_x;
   logic signed [VALUE_BITS-1:0] new_vel_y;
   logic signed [VALUE_BITS-1:0] new_vel_z;

   modport source (output valid, new_vel_x, new_vel_y, new_vel_z, input ready);
   modport sink (input valid, new_vel_x, new_vel_y, new_vel_z, output ready);
endinterface

// ===== hw/rtl/xsph_csr_if.sv =====
// Register write channel of the XSPH velocity smoothing block.
// No dependencies.
interface xsph_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [47:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/xsph_ctrl.sv =====
// Sequencer of the XSPH velocity smoothing block: state machine, axis and bit counters.
// Depends on xsph_pkg and the assertion macros header.
`include "xsph_velocity_smoothing_macros.svh"

module xsph_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  xsph_pkg::dp_status_type status,
   output xsph_pkg::dp_cmd_type    cmd
);
   import xsph_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic [5:0] bit_ff, bit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= 2'd0;
         bit_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         bit_ff   <= bit_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      bit_in   = bit_ff;
      case (state_ff)
         S_IDLE: begin
            axis_in = 2'd0;
            if (status.req_valid) begin
               if (!status.req_action) begin
                  state_in = S_IDLE;
               end else if (status.req_is_self) begin
                  state_in = S_END;
               end else begin
                  state_in = S_DIST;
               end
            end
         end
         S_DIST: state_in = S_SQ;
         S_SQ: begin
            if (axis_ff == 2'd2) begin
               state_in = S_WGT;
               axis_in  = 2'd0;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         S_WGT: state_in = status.in_range ? S_CUBE : S_END;
         S_CUBE: state_in = S_PLO;
         S_PLO: state_in = S_PHI;
         S_PHI: state_in = S_ACC;
         S_ACC: begin
            if (axis_ff == 2'd2) begin
               state_in = S_END;
               axis_in  = 2'd0;
            end else begin
               state_in = S_PLO;
               axis_in  = axis_ff + 2'd1;
            end
         end
         S_END: begin
            axis_in = 2'd0;
            if (!status.item_last) begin
               state_in = S_IDLE;
            end else if (status.pass_through) begin
               state_in = S_PASS;
            end else begin
               state_in = S_DIV_INIT;
            end
         end
         S_DIV_INIT: begin
            state_in = S_DIV;
            bit_in   = 6'd63;
         end
         S_DIV: begin
            if (bit_ff == 6'd0) begin
               state_in = S_CORR;
            end else begin
               bit_in = bit_ff - 6'd1;
            end
         end
         S_CORR: begin
            if (axis_ff == 2'd2) begin
               state_in = S_EMIT;
               axis_in  = 2'd0;
            end else begin
               state_in = S_DIV_INIT;
               axis_in  = axis_ff + 2'd1;
            end
         end
         S_PASS: begin
            if (axis_ff == 2'd2) begin
               state_in = S_EMIT;
               axis_in  = 2'd0;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            axis_in  = 2'd0;
         end
      endcase
   end

   always_comb begin
      cmd.op        = OP_NONE;
      cmd.axis      = axis_ff;
      cmd.req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) begin
               cmd.op = OP_LOAD;
            end
         end
         S_DIST:     cmd.op = OP_DIST;
         S_SQ:       cmd.op = OP_SQ;
         S_WGT:      cmd.op = OP_WGT;
         S_CUBE:     cmd.op = OP_CUBE;
         S_PLO:      cmd.op = OP_PLO;
         S_PHI:      cmd.op = OP_PHI;
         S_ACC:      cmd.op = OP_ACC;
         S_DIV_INIT: cmd.op = OP_DIV_INIT;
         S_DIV:      cmd.op = OP_DIV_STEP;
         S_CORR:     cmd.op = OP_CORR;
         S_PASS:     cmd.op = OP_PASS;
         S_EMIT:     cmd.op = status.out_free ? OP_EMIT : OP_NONE;
         default:    cmd.op = OP_NONE;
      endcase
   end

   `XSPH_ASSERT(a_axis_range, axis_ff != 2'd3, "axis counter out of range")
   `XSPH_ASSERT(a_div_start, state_ff == S_DIV_INIT |=> state_ff == S_DIV && bit_ff == 6'd63,
                "division did not start at the top bit")
   `XSPH_ASSERT(a_emit_idle, state_ff == S_EMIT && status.out_free |=> state_ff == S_IDLE,
                "result beat not followed by idle")
   `XSPH_ASSERT(a_ready_idle, cmd.req_ready |-> state_ff == S_IDLE && axis_ff == 2'd0,
                "input taken outside idle")

endmodule

// ===== hw/rtl/xsph_dpath.sv =====
// Datapath of the XSPH velocity smoothing block: registers, accumulators, divider, output.
// Depends on xsph_pkg and the channel interfaces.
module xsph_dpath #(
   parameter int VALUE_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   xsph_req_if.sink                req,
   xsph_rsp_if.source              rsp,
   xsph_csr_if.sink                csr,
   input  xsph_pkg::dp_cmd_type    cmd,
   output xsph_pkg::dp_status_type status
);
   import xsph_pkg::*;

   localparam int MW = VALUE_BITS + 1;
   localparam int PW = MW + 48;
   localparam logic signed [NW-1:0] OUT_HI = NW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
   localparam logic signed [NW-1:0] OUT_LO = -OUT_HI - NW'(1);
   localparam logic signed [64:0] SUM_HI = $signed({1'b0, SUM_MAX});
   localparam logic signed [64:0] SUM_LO = -SUM_HI;

   logic [16:0] gain_ff;
   logic [47:0] rsq_ff;
   logic [5:0]  shift_ff;

   logic signed [VALUE_BITS-1:0] pos_ff [3];
   logic signed [VALUE_BITS-1:0] vel_ff [3];
   logic signed [VALUE_BITS-1:0] cpos_ff [3];
   logic signed [VALUE_BITS-1:0] cvel_ff [3];
   logic signed [VALUE_BITS-1:0] nv_ff [3];
   logic signed [VALUE_BITS-1:0] out_ff [3];
   logic signed [63:0] sum_ff [3];
   logic [63:0] wt_ff;
   logic        last_ff;
   logic [25:0] d_ff [3];
   logic [51:0] r2_ff;
   logic [15:0] s16_ff;
   logic        sat_ff;
   logic [31:0] sq_ff;
   logic [47:0] w_ff;
   logic [MW-1:0]    m_ff;
   logic             neg_ff;
   logic [MW+23:0]   lo_ff;
   logic [MW+23:0]   hi_ff;
   logic [63:0] dvd_ff;
   logic [63:0] rem_ff;
   logic [63:0] quo_ff;
   logic        rsp_valid_ff;

   logic signed [VALUE_BITS-1:0] req_pos [3];
   logic signed [VALUE_BITS-1:0] req_vel [3];
   logic [25:0]      d_new [3];
   logic [47:0]      s_full;
   logic signed [MW-1:0] dv;
   logic [MW-1:0]    dv_mag;
   logic [PW-1:0]    p_full;
   logic [63:0]      p_mag;
   logic signed [64:0] p_signed;
   logic signed [64:0] sum_wide;
   logic signed [63:0] sum_sat;
   logic [63:0]      sum_mag;
   logic [63:0]      rem_sh;
   logic             rem_ge;
   logic [40:0]      q_clamp;
   logic [57:0]      corr_prod;
   logic signed [NW-1:0] cv_wide;
   logic signed [NW-1:0] corr_wide;
   logic signed [NW-1:0] nv_wide;
   logic signed [VALUE_BITS-1:0] nv_sat;

   assign req_pos[0] = req.pos_x;
   assign req_pos[1] = req.pos_y;
   assign req_pos[2] = req.pos_z;
   assign req_vel[0] = req.vel_x;
   assign req_vel[1] = req.vel_y;
   assign req_vel[2] = req.vel_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [MW-1:0] pd;
         logic [MW-1:0] pm;
         pd = $signed({cpos_ff[k][VALUE_BITS-1], cpos_ff[k]})
              - $signed({pos_ff[k][VALUE_BITS-1], pos_ff[k]});
         pm = pd[MW-1] ? MW'(-pd) : MW'(pd);
         d_new[k] = (64'(pm) > DIST_CLAMP) ? 26'(DIST_CLAMP) : 26'(pm);
      end
   end

   assign s_full = (rsq_ff - r2_ff[47:0]) >> shift_ff;

   assign dv = $signed({vel_ff[cmd.axis][VALUE_BITS-1], vel_ff[cmd.axis]})
               - $signed({cvel_ff[cmd.axis][VALUE_BITS-1], cvel_ff[cmd.axis]});
   assign dv_mag = dv[MW-1] ? MW'(-dv) : MW'(dv);

   always_comb begin
      p_full = (PW'(hi_ff) << 24) + PW'(lo_ff);
      p_mag  = (p_full > PW'(SUM_MAX)) ? SUM_MAX : p_full[63:0];
      p_signed = neg_ff ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
      sum_wide = $signed({sum_ff[cmd.axis][63], sum_ff[cmd.axis]}) + p_signed;
      if (sum_wide > SUM_HI) begin
         sum_sat = SUM_HI[63:0];
      end else if (sum_wide < SUM_LO) begin
         sum_sat = SUM_LO[63:0];
      end else begin
         sum_sat = sum_wide[63:0];
      end
   end

   assign sum_mag = sum_ff[cmd.axis][63] ? 64'(-sum_ff[cmd.axis]) : 64'(sum_ff[cmd.axis]);
   assign rem_sh  = {rem_ff[62:0], dvd_ff[63]};
   assign rem_ge  = rem_sh >= wt_ff;

   always_comb begin
      q_clamp   = (quo_ff > QUOT_CLAMP) ? 41'(QUOT_CLAMP) : quo_ff[40:0];
      corr_prod = 58'(q_clamp) * 58'(gain_ff);
      cv_wide   = {{(NW - VALUE_BITS){cvel_ff[cmd.axis][VALUE_BITS-1]}}, cvel_ff[cmd.axis]};
      corr_wide = $signed({3'b000, corr_prod[57:16]});
      nv_wide   = sum_ff[cmd.axis][63] ? cv_wide - corr_wide : cv_wide + corr_wide;
      if (nv_wide > OUT_HI) begin
         nv_sat = OUT_HI[VALUE_BITS-1:0];
      end else if (nv_wide < OUT_LO) begin
         nv_sat = OUT_LO[VALUE_BITS-1:0];
      end else begin
         nv_sat = nv_wide[VALUE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= 17'd0;
         rsq_ff   <= 48'd0;
         shift_ff <= SHIFT_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_GAIN:   gain_ff  <= csr.data[16:0];
            CSR_RADIUS: rsq_ff   <= csr.data;
            CSR_SHIFT:  shift_ff <= csr.data[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            cpos_ff[k] <= '0;
            cvel_ff[k] <= '0;
            sum_ff[k]  <= '0;
         end
         wt_ff <= '0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               last_ff <= req.last;
               for (int k = 0; k < 3; k++) begin
                  pos_ff[k] <= req_pos[k];
                  vel_ff[k] <= req_vel[k];
               end
               if (!req.action) begin
                  for (int k = 0; k < 3; k++) begin
                     cpos_ff[k] <= req_pos[k];
                     cvel_ff[k] <= req_vel[k];
                     sum_ff[k]  <= '0;
                  end
                  wt_ff <= '0;
               end
            end
            OP_DIST: begin
               for (int k = 0; k < 3; k++) begin
                  d_ff[k] <= d_new[k];
               end
               r2_ff <= '0;
            end
            OP_SQ: r2_ff <= r2_ff + 52'(d_ff[cmd.axis]) * 52'(d_ff[cmd.axis]);
            OP_WGT: begin
               s16_ff <= s_full[15:0];
               sat_ff <= s_full[47:16] != 32'd0;
               sq_ff  <= 32'(s_full[15:0]) * 32'(s_full[15:0]);
            end
            OP_CUBE: w_ff <= sat_ff ? WEIGHT_MAX : 48'(sq_ff) * 48'(s16_ff);
            OP_PLO: begin
               m_ff   <= dv_mag;
               neg_ff <= dv[MW-1];
               lo_ff  <= (MW + 24)'(dv_mag) * (MW + 24)'(w_ff[23:0]);
            end
            OP_PHI: hi_ff <= (MW + 24)'(m_ff) * (MW + 24)'(w_ff[47:24]);
            OP_ACC: begin
               sum_ff[cmd.axis] <= sum_sat;
               if (cmd.axis == 2'd2) begin
                  wt_ff <= (64'(w_ff) > SUM_MAX - wt_ff) ? SUM_MAX : wt_ff + 64'(w_ff);
               end
            end
            OP_DIV_INIT: begin
               dvd_ff <= sum_mag;
               rem_ff <= '0;
               quo_ff <= '0;
            end
            OP_DIV_STEP: begin
               rem_ff <= rem_ge ? rem_sh - wt_ff : rem_sh;
               dvd_ff <= {dvd_ff[62:0], 1'b0};
               quo_ff <= {quo_ff[62:0], rem_ge};
            end
            OP_CORR: nv_ff[cmd.axis] <= nv_sat;
            OP_PASS: nv_ff[cmd.axis] <= cvel_ff[cmd.axis];
            OP_EMIT: begin
               for (int k = 0; k < 3; k++) begin
                  out_ff[k] <= nv_ff[k];
                  sum_ff[k] <= '0;
               end
               wt_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign req.ready     = cmd.req_ready;
   assign csr.ready     = 1'b1;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.new_vel_x = out_ff[0];
   assign rsp.new_vel_y = out_ff[1];
   assign rsp.new_vel_z = out_ff[2];

   assign status.req_valid    = req.valid;
   assign status.req_action   = req.action;
   assign status.req_is_self  = req.is_self;
   assign status.item_last    = last_ff;
   assign status.in_range     = r2_ff <= 52'(rsq_ff);
   assign status.pass_through = (gain_ff == 17'd0) || (wt_ff == 64'd0);
   assign status.out_free     = !rsp_valid_ff || rsp.ready;

endmodule

// ===== hw/rtl/xsph_velocity_smoothing.sv =====
// XSPH velocity smoothing block, one particle at a time.
// req channel: a beat with action 0 loads the center particle; a beat
// with action 1 gives one neighbor. A neighbor with its is_self bit set is
// skipped, one outside the radius is dropped after the range check, and any
// other is weighted and summed per axis, the weight product in two 24-bit
// slices, low then high. req ready is high only while the sequencer idles.
// A neighbor with last set ends the list: one rsp beat follows. With gain 0
// or no weight the velocity passes through; otherwise a
// bit-serial 64-bit divider runs once per axis before its correction.
// The result sits in an output register; the next req beat is taken while it
// waits. When a second result is done before rsp ready takes the first, the
// sequencer holds until the output register frees.
// csr channel: always ready; index 0 gain, 1 radius squared, 2 weight shift.
// Reset (synchronous) zeroes center, sums, weight sum, gain and radius; shift resets to 32.
// Depends on xsph_pkg, the channel interfaces, xsph_ctrl and xsph_dpath.
module xsph_velocity_smoothing #(
   parameter int VALUE_BITS = 24
) (
   input logic        clock,
   input logic        reset,
   xsph_req_if.sink   req_ch,
   xsph_rsp_if.source rsp_ch,
   xsph_csr_if.sink   csr_ch
);
   import xsph_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   xsph_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   xsph_dpath #(.VALUE_BITS(VALUE_BITS)) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .rsp    (rsp_ch),
      .csr    (csr_ch),
      .cmd    (cmd),
      .status (status)
   );

endmodule
